>>> rtl/ecal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Epoch calendar package
// Constants and the March-based month start table shared by the datapath.
// ----------------------------------------------------------------------------
package ecal_pkg;

    localparam logic [25:0] DAY_RECIP   = 26'd50903317;
    localparam int          DAY_SHIFT   = 35;
    localparam logic [16:0] SECS_DAY    = 17'd86400;
    localparam logic [15:0] MAR68_OFS   = 16'd671;
    localparam logic [15:0] MAR2100_DAY = 16'd47541;
    localparam logic [15:0] QUAD_RECIP  = 16'd45934;
    localparam logic [10:0] QUAD_DAYS   = 11'd1461;
    localparam logic [8:0]  YEAR_DAYS   = 9'd365;
    localparam logic [11:0] BASE_YEAR   = 12'd1968;
    localparam logic [16:0] WEEK_RECIP  = 17'd74899;
    localparam logic [12:0] MON_RECIP   = 13'd6854;
    localparam logic [12:0] HOUR_RECIP  = 13'd4661;
    localparam logic [11:0] SECS_HOUR   = 12'd3600;
    localparam logic [10:0] MIN_RECIP   = 11'd1093;

    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] s;
        unique case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

>>> rtl/epoch_seconds_to_calendar_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Epoch seconds to calendar core
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00
// into Gregorian year, month, day, hour, minute, second and weekday.
//
// The input word is taken when i_valid and o_ready are both high; the
// result word leaves when o_valid and i_ready are both high.
// The datapath is an eight-stage pipeline: three stages split days from
// the time of day, then five stages form the date and the clock fields
// in parallel. One word can enter on every cycle while the receiver
// does not hold i_ready low with a result waiting.
// All stages advance together. When the receiver holds i_ready low with
// a result waiting, the whole pipeline freezes and o_ready drops, so no
// word is lost or repeated. Reset clears the stage valid bits; the data
// registers are not reset.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_core import ecal_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_epoch_seconds,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [11:0] o_year_value,
    output logic      [3:0]  o_month_value,
    output logic      [4:0]  o_day_of_month,
    output logic      [4:0]  o_hour_value,
    output logic      [5:0]  o_minute_value,
    output logic      [5:0]  o_second_value,
    output logic      [2:0]  o_weekday_value
);

    logic [7:0]  r_vld;
    logic        w_en;
    logic [15:0] w_days;
    logic [15:0] w_days_mar;
    logic [16:0] w_tod;

    assign w_en    = ~r_vld[7] | i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[6:0], i_valid};
        end
    end

    ecal_split u_split (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_secs     (i_epoch_seconds),
        .o_days     (w_days),
        .o_days_mar (w_days_mar),
        .o_tod      (w_tod)
    );

    ecal_date u_date (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_days     (w_days),
        .i_days_mar (w_days_mar),
        .o_year     (o_year_value),
        .o_month    (o_month_value),
        .o_day      (o_day_of_month),
        .o_weekday  (o_weekday_value)
    );

    ecal_clock u_clock (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_tod    (w_tod),
        .o_hour   (o_hour_value),
        .o_minute (o_minute_value),
        .o_second (o_second_value)
    );

`ifndef NO_ASSERTIONS
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month_value >= 4'd1 && o_month_value <= 4'd12))
        else $error("month out of range");
    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_day_of_month >= 5'd1))
        else $error("day of month is zero");
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hour_value < 5'd24 && o_minute_value < 6'd60
                     && o_second_value < 6'd60))
        else $error("time of day out of range");
    a_week_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_weekday_value < 3'd7))
        else $error("weekday out of range");
`endif

endmodule
`default_nettype wire

>>> rtl/ecal_split.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Day split
// Three stages that separate whole days from the time of day.
// ----------------------------------------------------------------------------
module ecal_split import ecal_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_secs,
    output logic      [15:0] o_days,
    output logic      [15:0] o_days_mar,
    output logic      [16:0] o_tod
);

    logic [50:0] r_prod1;
    logic [31:0] r_secs1;
    logic [15:0] r_days2;
    logic [31:0] r_secs2;
    logic [15:0] r_days3;
    logic [15:0] r_mar3;
    logic [16:0] r_tod3;
    logic [31:0] n_tod;
    logic [15:0] n_mar;

    always_comb begin
        n_tod = r_secs2 - (32'(r_days2) * 32'(SECS_DAY));
        n_mar = r_days2 + MAR68_OFS + 16'(r_days2 >= MAR2100_DAY);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod1 <= 51'(i_secs[31:7]) * 51'(DAY_RECIP);
            r_secs1 <= i_secs;
            r_days2 <= r_prod1[DAY_SHIFT +: 16];
            r_secs2 <= r_secs1;
            r_days3 <= r_days2;
            r_mar3  <= n_mar;
            r_tod3  <= n_tod[16:0];
        end
    end

    assign o_days     = r_days3;
    assign o_days_mar = r_mar3;
    assign o_tod      = r_tod3;

endmodule
`default_nettype wire

>>> rtl/ecal_date.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Date unit
// Five stages from a March-based day count to year, month, day and weekday.
// ----------------------------------------------------------------------------
module ecal_date import ecal_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [15:0] i_days,
    input  wire logic [15:0] i_days_mar,
    output logic      [11:0] o_year,
    output logic      [3:0]  o_month,
    output logic      [4:0]  o_day,
    output logic      [2:0]  o_weekday
);

    logic [31:0] r_cp4;
    logic [15:0] r_mar4;
    logic [15:0] r_wx4;
    logic [32:0] r_wp4;
    logic [5:0]  r_cyc5;
    logic [10:0] r_rem5;
    logic [2:0]  r_wk5;
    logic [8:0]  r_doy6;
    logic [11:0] r_ym6;
    logic [2:0]  r_wk6;
    logic [23:0] r_mpp7;
    logic [8:0]  r_doy7;
    logic [11:0] r_ym7;
    logic [2:0]  r_wk7;
    logic [11:0] r_year8;
    logic [3:0]  r_month8;
    logic [4:0]  r_day8;
    logic [2:0]  r_wk8;

    logic [15:0] n_rem;
    logic [15:0] n_wk;
    logic [1:0]  n_yoff;
    logic [10:0] n_doy;
    logic [3:0]  n_mp;
    logic [8:0]  n_day;

    always_comb begin
        n_rem = r_mar4 - (16'(r_cp4[31:26]) * 16'(QUAD_DAYS));
        n_wk  = r_wx4 - (16'(r_wp4[32:19]) * 16'd7);
        priority if (r_rem5 >= 11'd1095) begin
            n_yoff = 2'd3;
        end else if (r_rem5 >= 11'd730) begin
            n_yoff = 2'd2;
        end else if (r_rem5 >= 11'd365) begin
            n_yoff = 2'd1;
        end else begin
            n_yoff = 2'd0;
        end
        n_doy = r_rem5 - (11'(n_yoff) * 11'(YEAR_DAYS));
        n_mp  = r_mpp7[23:20];
        n_day = r_doy7 - month_start(n_mp) + 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cp4    <= 32'(i_days_mar) * 32'(QUAD_RECIP);
            r_mar4   <= i_days_mar;
            r_wx4    <= i_days + 16'd4;
            r_wp4    <= 33'(i_days + 16'd4) * 33'(WEEK_RECIP);
            r_cyc5   <= r_cp4[31:26];
            r_rem5   <= n_rem[10:0];
            r_wk5    <= n_wk[2:0];
            r_doy6   <= n_doy[8:0];
            r_ym6    <= BASE_YEAR + {4'd0, r_cyc5, 2'd0} + 12'(n_yoff);
            r_wk6    <= r_wk5;
            r_mpp7   <= 24'(11'(r_doy6) * 11'd5 + 11'd2) * 24'(MON_RECIP);
            r_doy7   <= r_doy6;
            r_ym7    <= r_ym6;
            r_wk7    <= r_wk6;
            r_day8   <= n_day[4:0];
            r_month8 <= (n_mp < 4'd10) ? n_mp + 4'd3 : n_mp - 4'd9;
            r_year8  <= r_ym7 + 12'(n_mp >= 4'd10);
            r_wk8    <= r_wk7;
        end
    end

    assign o_year    = r_year8;
    assign o_month   = r_month8;
    assign o_day     = r_day8;
    assign o_weekday = r_wk8;

endmodule
`default_nettype wire

>>> rtl/ecal_clock.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Time of day unit
// Five stages from seconds of the day to hour, minute and second.
// ----------------------------------------------------------------------------
module ecal_clock import ecal_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [16:0] i_tod,
    output logic      [4:0]  o_hour,
    output logic      [5:0]  o_minute,
    output logic      [5:0]  o_second
);

    logic [25:0] r_hp4;
    logic [16:0] r_tod4;
    logic [4:0]  r_hour5;
    logic [11:0] r_remh5;
    logic [20:0] r_minp6;
    logic [4:0]  r_hour6;
    logic [11:0] r_remh6;
    logic [4:0]  r_hour7;
    logic [5:0]  r_min7;
    logic [5:0]  r_sec7;
    logic [4:0]  r_hour8;
    logic [5:0]  r_min8;
    logic [5:0]  r_sec8;

    logic [16:0] n_remh;
    logic [11:0] n_sec;

    always_comb begin
        n_remh = r_tod4 - (17'(r_hp4[24:20]) * 17'(SECS_HOUR));
        n_sec  = r_remh6 - (12'(r_minp6[19:14]) * 12'd60);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hp4   <= 26'(i_tod[16:4]) * 26'(HOUR_RECIP);
            r_tod4  <= i_tod;
            r_hour5 <= r_hp4[24:20];
            r_remh5 <= n_remh[11:0];
            r_minp6 <= 21'(r_remh5[11:2]) * 21'(MIN_RECIP);
            r_hour6 <= r_hour5;
            r_remh6 <= r_remh5;
            r_hour7 <= r_hour6;
            r_min7  <= r_minp6[19:14];
            r_sec7  <= n_sec[5:0];
            r_hour8 <= r_hour7;
            r_min8  <= r_min7;
            r_sec8  <= r_sec7;
        end
    end

    assign o_hour   = r_hour8;
    assign o_minute = r_min8;
    assign o_second = r_sec8;

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds to calendar core testbench
// Drives random and corner-case second counts through the core with random
// gaps and stalls on both sides, and checks every calendar word that comes
// out against a date found here by year and month stepping and a weekday formula.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  wday;
    } t_calendar;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_epoch_seconds;
    logic        o_valid;
    logic        i_ready;
    logic [11:0] o_year_value;
    logic [3:0]  o_month_value;
    logic [4:0]  o_day_of_month;
    logic [4:0]  o_hour_value;
    logic [5:0]  o_minute_value;
    logic [5:0]  o_second_value;
    logic [2:0]  o_weekday_value;

    logic [31:0] seconds_queue[$];
    t_calendar   expected_dates[$];
    int          error_count;
    bit          stimulus_done;
    bit          sender_hold;
    bit          no_idle;

    epoch_seconds_to_calendar_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_epoch_seconds(i_epoch_seconds),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_year_value(o_year_value), .o_month_value(o_month_value),
        .o_day_of_month(o_day_of_month), .o_hour_value(o_hour_value),
        .o_minute_value(o_minute_value), .o_second_value(o_second_value),
        .o_weekday_value(o_weekday_value)
    );

    function automatic bit is_leap(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic t_calendar to_calendar(logic [31:0] secs);
        int unsigned days, tod, y, m, d, len, wy, wm;
        int unsigned month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        t_calendar c;
        days = secs / 86400;
        tod  = secs % 86400;
        y    = 1970;
        m    = 0;
        while (days >= 365) begin
            if (is_leap(y)) begin
                if (days < 366) break;
                days -= 366;
            end else begin
                days -= 365;
            end
            y++;
        end
        while (m < 12) begin
            len = month_len[m];
            if (is_leap(y) && m == 1) len = 29;
            if (days < len) break;
            days -= len;
            m++;
        end
        if (m > 11) m = 11;
        d  = days + 1;
        wm = m + 1;
        wy = y;
        if (wm < 3) begin
            wm += 12;
            wy -= 1;
        end
        c.year   = y[11:0];
        c.month  = 4'(m + 1);
        c.mday   = d[4:0];
        c.hour   = 5'(tod / 3600);
        c.minute = 6'((tod % 3600) / 60);
        c.second = 6'(tod % 60);
        c.wday   = 3'((d + 1 + 2 * wm + (3 * (wm + 1)) / 5 + wy + (wy >> 2)
                       - wy / 100 + wy / 400) % 7);
        return c;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        int unsigned y, base;
        i_rst_n       = 1'b0;
        stimulus_done = 1'b0;
        sender_hold   = 1'b0;
        no_idle       = 1'b0;
        error_count   = 0;
        seconds_queue.push_back(32'd0);
        seconds_queue.push_back(32'hFFFF_FFFF);
        seconds_queue.push_back(32'd86399);
        seconds_queue.push_back(32'd86400);
        seconds_queue.push_back(32'd951782399);
        seconds_queue.push_back(32'd951782400);
        seconds_queue.push_back(32'd951868800);
        seconds_queue.push_back(32'd4107542399);
        seconds_queue.push_back(32'd4107542400);
        seconds_queue.push_back(32'd4102444799);
        seconds_queue.push_back(32'd68169600);
        seconds_queue.push_back(32'd78796799);
        seconds_queue.push_back(32'hAAAA_AAAA);
        seconds_queue.push_back(32'h5555_5555);
        seconds_queue.push_back(32'h8000_0000);
        seconds_queue.push_back(32'h7FFF_FFFF);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (seconds_queue.size() == 0);
        wait (expected_dates.size() == 0);
        sender_hold = 1'b1;
        repeat (12) @(posedge i_clk);
        sender_hold = 1'b0;
        for (int i = 0; i < 730; i++) begin
            case ($urandom_range(3))
                0: seconds_queue.push_back($urandom);
                1: begin
                    y = $urandom_range(2105, 1970);
                    base = 0;
                    for (int k = 1970; k < y; k++) base += is_leap(k) ? 366 : 365;
                    base += $urandom_range(is_leap(y) ? 365 : 364);
                    seconds_queue.push_back(base * 86400 + $urandom_range(1) * 86399);
                end
                2: seconds_queue.push_back(($urandom / 86400) * 86400
                                           + $urandom_range(2) * 43199);
                default: seconds_queue.push_back(
                    32'hFFFF_FFFF - $urandom_range(2000000));
            endcase
            if (i == 200) no_idle = 1'b1;
            if (i == 350) no_idle = 1'b0;
            if (i % 100 == 99) wait (seconds_queue.size() < 20);
        end
        wait (seconds_queue.size() == 0);
        stimulus_done = 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid         <= 1'b0;
            i_epoch_seconds <= 32'd0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) void'(seconds_queue.pop_front());
            if (seconds_queue.size() > 0 && !sender_hold
                && (no_idle || $urandom_range(99) >= 30)) begin
                i_valid         <= 1'b1;
                i_epoch_seconds <= seconds_queue[0];
                expected_dates.push_back(to_calendar(seconds_queue[0]));
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_calendar want, got;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got = '{o_year_value, o_month_value, o_day_of_month, o_hour_value,
                        o_minute_value, o_second_value, o_weekday_value};
                if (expected_dates.size() == 0) begin
                    $display("%0t: unexpected word %p", $time, got);
                    error_count++;
                end else begin
                    want = expected_dates.pop_front();
                    if (want !== got) begin
                        $display("%0t: expected %p actual %p", $time, want, got);
                        error_count++;
                    end
                end
            end
            i_ready <= no_idle || ($urandom_range(99) >= 30);
        end
    end

    initial begin
        wait (stimulus_done);
        wait (expected_dates.size() == 0);
        repeat (40) @(posedge i_clk);
        if (error_count == 0 && expected_dates.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("FAIL");
        $finish;
    end

endmodule
